@@ rtl/hex_text_to_byte_parser_core_defines.svh @@
// assertion macros used by the checker of the hex text parser
`ifndef HEX_TEXT_TO_BYTE_PARSER_CORE_DEFINES_SVH
`define HEX_TEXT_TO_BYTE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define HEXP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hexp check failed");

// next-cycle implication, disabled while reset is held
`define HEXP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hexp check failed");

`endif

@@ rtl/hexp_pkg.sv @@
`timescale 1ns / 1ps

package hexp_pkg;

    // widths of the word fields
    localparam int CHAR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int OUT_LINE_W = 20;

    // internal line counter width
    localparam int LINE_BITS  = 20;
    localparam int LINE_EXT_W = (LINE_BITS > OUT_LINE_W) ? LINE_BITS : OUT_LINE_W;

    // input action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // result kind codes
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
    localparam logic [CHAR_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 16'h0078;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 16'h0058;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LOW_F = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 16'h0046;

    // scanner mode
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_TOKEN   = 4'b0010,
        MODE_SLASH   = 4'b0100,
        MODE_COMMENT = 4'b1000
    } hexp_mode_t;

    // end-of-text status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_HEX = 2'd1,
        ST_ODD     = 2'd2
    } hexp_status_t;

    // one input word
    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_code;
    } hexp_item_t;

    // result of one step
    typedef struct packed {
        logic                  emit;
        logic                  kind;
        logic [BYTE_W-1:0]     data_byte;
        hexp_status_t          status;
        logic [OUT_LINE_W-1:0] error_line;
    } hexp_result_t;

    // hex digit decode: bit 4 set when the code is a hex digit
    function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            d = c - CH_LOW_A + 16'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = c - CH_UP_A + 16'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

    // clamp a line number to the output field
    function automatic logic [OUT_LINE_W-1:0] clamp_line(input logic [LINE_BITS-1:0] ln);
        logic [LINE_EXT_W-1:0] ext;
        ext = LINE_EXT_W'(ln);
        if (ext > LINE_EXT_W'({OUT_LINE_W{1'b1}})) begin
            return {OUT_LINE_W{1'b1}};
        end
        return ext[OUT_LINE_W-1:0];
    endfunction

endpackage

@@ rtl/hexp_parse.sv @@
`timescale 1ns / 1ps

module hexp_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  hexp_pkg::hexp_item_t item,
    output hexp_pkg::hexp_result_t result
);
    import hexp_pkg::*;

    hexp_mode_t           mode_reg, mode_next;
    logic [1:0]           pos_reg, pos_next;
    logic                 prefix_reg, prefix_next;
    logic [3:0]           high_reg, high_next;
    logic                 pend_reg, pend_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    hexp_status_t         err_reg, err_next;
    logic [LINE_BITS-1:0] err_line_reg, err_line_next;

    // next state and result for the word at hand
    always_comb begin
        logic [CHAR_W-1:0] c;
        logic [4:0]        hx;
        logic              is_sep;
        logic              is_x;
        logic              close_err;
        hexp_status_t      close_code;

        c      = item.char_code;
        hx     = hex_decode(c);
        is_sep = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
        is_x   = (c == CH_LOW_X) || (c == CH_UP_X);

        // error raised by closing the open token
        close_err  = 1'b0;
        close_code = ST_NOT_HEX;
        if (mode_reg == MODE_TOKEN) begin
            if (prefix_reg) begin
                close_err = 1'b1;
            end else if (pend_reg) begin
                close_err  = 1'b1;
                close_code = ST_ODD;
            end
        end else if (mode_reg == MODE_SLASH) begin
            close_err = 1'b1;
        end

        mode_next     = mode_reg;
        pos_next      = pos_reg;
        prefix_next   = prefix_reg;
        high_next     = high_reg;
        pend_next     = pend_reg;
        prev_cr_next  = prev_cr_reg;
        line_next     = line_reg;
        err_next      = err_reg;
        err_line_next = err_line_reg;

        result            = '0;
        result.status     = ST_OK;

        if (item.action == ACT_END) begin
            // status word, then everything back to reset
            result.emit = 1'b1;
            result.kind = KIND_STATUS;
            if (err_reg != ST_OK) begin
                result.status     = err_reg;
                result.error_line = clamp_line(err_line_reg);
            end else if (close_err) begin
                result.status     = close_code;
                result.error_line = clamp_line(line_reg);
            end
            mode_next     = MODE_IDLE;
            pos_next      = '0;
            prefix_next   = 1'b0;
            high_next     = '0;
            pend_next     = 1'b0;
            prev_cr_next  = 1'b0;
            line_next     = LINE_BITS'(1);
            err_next      = ST_OK;
            err_line_next = '0;
        end else if (err_reg != ST_OK) begin
            // latched error: characters are dropped
        end else if (c == CH_CR || c == CH_LF) begin
            // line break closes the token and counts a line
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            prefix_next = 1'b0;
            high_next   = '0;
            pend_next   = 1'b0;
            if (close_err) begin
                err_next      = close_code;
                err_line_next = line_reg;
            end else begin
                if ((c == CH_CR || !prev_cr_reg) && line_reg != {LINE_BITS{1'b1}}) begin
                    line_next = line_reg + LINE_BITS'(1);
                end
                prev_cr_next = (c == CH_CR);
            end
        end else begin
            prev_cr_next = 1'b0;
            if (mode_reg == MODE_COMMENT) begin
                // comment text is skipped
            end else if (mode_reg == MODE_SLASH) begin
                if (c == CH_SLASH) begin
                    mode_next = MODE_COMMENT;
                end else begin
                    err_next      = ST_NOT_HEX;
                    err_line_next = line_reg;
                end
            end else if (is_sep) begin
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                prefix_next = 1'b0;
                high_next   = '0;
                pend_next   = 1'b0;
                if (close_err) begin
                    err_next      = close_code;
                    err_line_next = line_reg;
                end
            end else if (mode_reg == MODE_IDLE && c == CH_HASH) begin
                mode_next = MODE_COMMENT;
            end else if (mode_reg == MODE_IDLE && c == CH_SLASH) begin
                mode_next = MODE_SLASH;
            end else begin
                // token character
                if (mode_reg == MODE_IDLE) begin
                    pos_next    = '0;
                    prefix_next = 1'b0;
                    pend_next   = 1'b0;
                    high_next   = '0;
                end
                mode_next = MODE_TOKEN;
                if (pos_next == 2'd1 && is_x && pend_next && high_next == 4'd0) begin
                    prefix_next = 1'b1;
                    pend_next   = 1'b0;
                    pos_next    = 2'd2;
                end else if (!hx[4]) begin
                    err_next      = ST_NOT_HEX;
                    err_line_next = line_reg;
                end else begin
                    prefix_next = 1'b0;
                    if (pos_next != 2'd2) begin
                        pos_next = pos_next + 2'd1;
                    end
                    if (pend_next) begin
                        pend_next        = 1'b0;
                        result.emit      = 1'b1;
                        result.kind      = KIND_DATA;
                        result.data_byte = {high_next, hx[3:0]};
                    end else begin
                        high_next = hx[3:0];
                        pend_next = 1'b1;
                    end
                end
            end
        end
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            prefix_reg   <= 1'b0;
            high_reg     <= '0;
            pend_reg     <= 1'b0;
            prev_cr_reg  <= 1'b0;
            line_reg     <= LINE_BITS'(1);
            err_reg      <= ST_OK;
            err_line_reg <= '0;
        end else if (step_en) begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            prefix_reg   <= prefix_next;
            high_reg     <= high_next;
            pend_reg     <= pend_next;
            prev_cr_reg  <= prev_cr_next;
            line_reg     <= line_next;
            err_reg      <= err_next;
            err_line_reg <= err_line_next;
        end
    end

endmodule

@@ rtl/hex_text_to_byte_parser_core.sv @@
`timescale 1ns / 1ps

// Hex text parser: takes character words and sends a byte word for every
// second hex digit, plus one status word for each end-of-text word. The
// sustained rate is one input word per clock while results drain, set by the
// scanner state update between the input register and the result register; a
// result is registered when the scanner steps on its input word, and a stalled
// result holds the input register until it is drained. On a non-ok status the
// bytes already sent for that text are to be dropped downstream.
module hex_text_to_byte_parser_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [hexp_pkg::CHAR_W-1:0]       s_char_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [hexp_pkg::BYTE_W-1:0]       m_data_byte,
    output logic [1:0]                        m_status,
    output logic [hexp_pkg::OUT_LINE_W-1:0]   m_error_line
);
    import hexp_pkg::*;

    logic         in_valid_reg;
    hexp_item_t   in_item_reg;
    logic         out_valid_reg;
    hexp_result_t out_reg;
    hexp_result_t step_result;
    logic         advance;

    // step the scanner when the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.action    <= s_action;
            in_item_reg.char_code <= s_char_code;
        end
    end

    hexp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_result.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_result.emit) begin
            out_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_reg.kind;
    assign m_data_byte  = out_reg.data_byte;
    assign m_status     = out_reg.status;
    assign m_error_line = out_reg.error_line;

endmodule

@@ rtl/hexp_checker.sv @@
`timescale 1ns / 1ps
`include "hex_text_to_byte_parser_core_defines.svh"

module hexp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_kind,
    input logic [hexp_pkg::BYTE_W-1:0]     m_data_byte,
    input logic [1:0]                      m_status,
    input logic [hexp_pkg::OUT_LINE_W-1:0] m_error_line
);
    import hexp_pkg::*;

    // byte words carry no status and no line
    `HEXP_ASSERT_NOW(a_data_clean, aclk, aresetn, m_valid && m_kind == KIND_DATA, m_status == ST_OK && m_error_line == '0)

    // ok status reports line zero
    `HEXP_ASSERT_NOW(a_ok_line_zero, aclk, aresetn, m_valid && m_kind == KIND_STATUS && m_status == ST_OK, m_error_line == '0)

    // an error status names a real line
    `HEXP_ASSERT_NOW(a_err_line_set, aclk, aresetn, m_valid && m_kind == KIND_STATUS && m_status != ST_OK, m_error_line != '0)

    // no status code beyond odd digit count
    `HEXP_ASSERT_NOW(a_status_range, aclk, aresetn, m_valid, m_status == ST_OK || m_status == ST_NOT_HEX || m_status == ST_ODD)

    // a stalled result word holds
    `HEXP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_data_byte) && $stable(m_status) && $stable(m_error_line))

endmodule

bind hex_text_to_byte_parser_core hexp_checker u_hexp_checker (.*);

@@ tb/hex_text_to_byte_parser_core_tb.sv @@
`timescale 1ns / 1ps

module hex_text_to_byte_parser_core_tb;

    import hexp_pkg::*;

    localparam int GAP_TOP        = 4;
    localparam int RANDOM_WORDS   = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_LIMIT   = 100;
    localparam int FEED_DEPTH     = 64;

    // one result word as the block should send it
    typedef struct packed {
        logic                  kind;
        logic [BYTE_W-1:0]     data_byte;
        hexp_status_t          status;
        logic [OUT_LINE_W-1:0] error_line;
    } parsed_word_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_action    = ACT_CHAR;
    logic [CHAR_W-1:0]     s_char_code = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_kind;
    logic [BYTE_W-1:0]     m_data_byte;
    logic [1:0]            m_status;
    logic [OUT_LINE_W-1:0] m_error_line;

    hexp_item_t   text_q[$];
    parsed_word_t parsed_q[$];

    int unsigned err_cnt   = 0;
    int unsigned words_fed = 0;
    bit          no_gaps   = 1'b0;
    int          send_wait = 0;
    int          take_wait = 0;
    int          idle_cycles = 0;

    // scanner state mirrored from the block's behaviour
    hexp_mode_t           scan_st;
    logic [1:0]           tok_pos;
    logic                 pfx_only;
    logic [3:0]           hi_nib;
    logic                 nib_held;
    logic                 was_cr;
    logic [LINE_BITS-1:0] line_no;
    hexp_status_t         err_st;
    logic [LINE_BITS-1:0] err_ln;

    hex_text_to_byte_parser_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_status     (m_status),
        .m_error_line (m_error_line)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------- scanner mirror

    function automatic int nib_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    function automatic logic [OUT_LINE_W-1:0] line_field(input logic [LINE_BITS-1:0] ln);
        longint unsigned wide;
        longint unsigned top;
        wide = ln;
        top  = (64'd1 << OUT_LINE_W) - 1;
        if (wide > top) return '1;
        return OUT_LINE_W'(wide);
    endfunction

    task automatic scanner_clear();
        scan_st  = MODE_IDLE;
        tok_pos  = '0;
        pfx_only = 1'b0;
        hi_nib   = '0;
        nib_held = 1'b0;
        was_cr   = 1'b0;
        line_no  = LINE_BITS'(1);
        err_st   = ST_OK;
        err_ln   = '0;
    endtask

    // only the first error of a text is kept
    task automatic latch_error(input hexp_status_t code);
        if (err_st == ST_OK) begin
            err_st = code;
            err_ln = line_no;
        end
    endtask

    task automatic close_token();
        if (scan_st == MODE_TOKEN) begin
            if (pfx_only) latch_error(ST_NOT_HEX);
            else if (nib_held) latch_error(ST_ODD);
        end else if (scan_st == MODE_SLASH) begin
            latch_error(ST_NOT_HEX);
        end
        scan_st  = MODE_IDLE;
        tok_pos  = '0;
        pfx_only = 1'b0;
        nib_held = 1'b0;
        hi_nib   = '0;
    endtask

    // advance the mirror by one accepted input word
    task automatic scan_word(input logic act, input logic [CHAR_W-1:0] c);
        parsed_word_t w;
        int           v;
        w = '0;
        if (act == ACT_END) begin
            if (err_st == ST_OK) close_token();
            w.kind       = KIND_STATUS;
            w.status     = err_st;
            w.error_line = (err_st != ST_OK) ? line_field(err_ln) : '0;
            parsed_q = {parsed_q, w};
            scanner_clear();
            return;
        end
        if (err_st != ST_OK) return;

        // line breaks, with cr then lf counted once
        if (c == CH_CR || c == CH_LF) begin
            close_token();
            if (err_st != ST_OK) return;
            if ((c == CH_CR || !was_cr) && line_no != {LINE_BITS{1'b1}}) line_no = line_no + 1'b1;
            was_cr = (c == CH_CR);
            return;
        end
        was_cr = 1'b0;

        if (scan_st == MODE_COMMENT) return;
        if (scan_st == MODE_SLASH) begin
            if (c == CH_SLASH) scan_st = MODE_COMMENT;
            else latch_error(ST_NOT_HEX);
            return;
        end
        if (c == CH_SPACE || c == CH_TAB || c == CH_COMMA) begin
            close_token();
            return;
        end

        // start of a token, or of a comment
        if (scan_st == MODE_IDLE) begin
            if (c == CH_HASH) begin
                scan_st = MODE_COMMENT;
                return;
            end
            if (c == CH_SLASH) begin
                scan_st = MODE_SLASH;
                return;
            end
            scan_st  = MODE_TOKEN;
            tok_pos  = '0;
            pfx_only = 1'b0;
            nib_held = 1'b0;
            hi_nib   = '0;
        end

        // leading zero then x is a prefix
        if (tok_pos == 2'd1 && (c == CH_LOW_X || c == CH_UP_X) && nib_held && hi_nib == 4'd0) begin
            pfx_only = 1'b1;
            nib_held = 1'b0;
            tok_pos  = 2'd2;
            return;
        end

        v = nib_value(c);
        if (v < 0) begin
            latch_error(ST_NOT_HEX);
            return;
        end
        pfx_only = 1'b0;
        if (tok_pos < 2'd2) tok_pos = tok_pos + 1'b1;
        if (nib_held) begin
            nib_held    = 1'b0;
            w.kind      = KIND_DATA;
            w.data_byte = {hi_nib, v[3:0]};
            w.status    = ST_OK;
            parsed_q = {parsed_q, w};
        end else begin
            hi_nib   = v[3:0];
            nib_held = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin
        hexp_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
            scanner_clear();
        end else begin
            if (s_valid && s_ready) scan_word(s_action, s_char_code);
            // slot free: either wait out the gap or present the next word
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    nxt = text_q.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= nxt.action;
                    s_char_code <= nxt.char_code;
                    send_wait = no_gaps ? 0 : $urandom_range(0, GAP_TOP);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        parsed_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (parsed_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT)
                        $error("unexpected result word: kind %0d, byte %02h, status %0d, line %0d",
                               m_kind, m_data_byte, m_status, m_error_line);
                end else begin
                    want = parsed_q.pop_front();
                    if (m_kind !== want.kind) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_LIMIT)
                            $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    end
                    if (m_data_byte !== want.data_byte) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_LIMIT)
                            $error("data_byte: expected %02h, got %02h",
                                   want.data_byte, m_data_byte);
                    end
                    if (m_status !== want.status) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_LIMIT)
                            $error("status: expected %0d, got %0d", want.status, m_status);
                    end
                    if (m_error_line !== want.error_line) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_LIMIT)
                            $error("error_line: expected %0d, got %0d",
                                   want.error_line, m_error_line);
                    end
                end
                take_wait = no_gaps ? 0 : $urandom_range(0, GAP_TOP);
            end else if (take_wait > 0) begin
                take_wait--;
            end
            m_ready <= (take_wait == 0);
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("hex_text_to_byte_parser_core_tb: done, errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    task automatic put_word(input logic act, input logic [CHAR_W-1:0] c);
        hexp_item_t it;
        while (text_q.size() >= FEED_DEPTH) @(negedge aclk);
        it.action    = act;
        it.char_code = c;
        text_q = {text_q, it};
        words_fed++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] c);
        put_word(ACT_CHAR, c);
    endtask

    // the code unit of an end word is noise and must be ignored
    task automatic put_end();
        put_word(ACT_END, CHAR_W'($urandom));
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_char(CHAR_W'(s[i]));
    endtask

    task automatic put_digits(input int n);
        string pool;
        pool = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++) put_char(CHAR_W'(pool[$urandom_range(0, 21)]));
    endtask

    task automatic put_prefix();
        put_char(CH_ZERO);
        put_char($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
    endtask

    task automatic put_break();
        case ($urandom_range(0, 2))
            0: put_char(CH_LF);
            1: put_char(CH_CR);
            default: begin
                put_char(CH_CR);
                put_char(CH_LF);
            end
        endcase
    endtask

    task automatic put_sep();
        case ($urandom_range(0, 5))
            0: put_char(CH_SPACE);
            1: put_char(CH_TAB);
            2: put_char(CH_COMMA);
            default: put_break();
        endcase
    endtask

    // anything at all, weighted towards awkward codes
    function automatic logic [CHAR_W-1:0] odd_code();
        case ($urandom_range(0, 7))
            0: return CHAR_W'($urandom);
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return CH_LOW_X;
            4: return CH_UP_X;
            5: return $urandom_range(0, 1) ? 16'h0067 : 16'h0047;
            6: return 16'h8000 | CHAR_W'($urandom);
            default: return CHAR_W'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic put_comment();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 1)) put_char(CH_HASH);
        else put_str("//");
        repeat ($urandom_range(0, 5)) begin
            c = $urandom_range(0, 1) ? CHAR_W'($urandom) : CHAR_W'($urandom_range(32, 126));
            if (c == CH_CR || c == CH_LF) c = 16'h007A;
            put_char(c);
        end
        if ($urandom_range(0, 7) != 0) put_break();
    endtask

    task automatic put_good_token();
        if ($urandom_range(0, 3) == 0) put_prefix();
        put_digits(2 * $urandom_range(1, 4));
    endtask

    // a token aimed at one of the errors, though a random draw can still parse clean
    task automatic put_bad_token();
        case ($urandom_range(0, 5))
            0: begin
                if ($urandom_range(0, 1)) put_prefix();
                put_digits(2 * $urandom_range(0, 2) + 1);
            end
            1: begin
                put_digits($urandom_range(0, 3));
                put_char(odd_code());
                put_digits($urandom_range(0, 2));
            end
            2: begin
                put_char(CH_SLASH);
                case ($urandom_range(0, 2))
                    0: put_sep();
                    1: put_digits(1);
                    default: put_char(odd_code());
                endcase
            end
            3: put_prefix();
            4: begin
                put_digits($urandom_range(1, 3));
                put_char($urandom_range(0, 1) ? CH_HASH : CH_SLASH);
            end
            default: repeat ($urandom_range(1, 6)) put_char(odd_code());
        endcase
    endtask

    // one text: mostly well-formed, sometimes with one broken token
    task automatic put_text();
        int  n_tok;
        int  bad_at;
        bit  broken;
        n_tok  = $urandom_range(1, 10);
        broken = ($urandom_range(0, 99) < 35);
        bad_at = $urandom_range(0, n_tok - 1);
        for (int t = 0; t < n_tok; t++) begin
            if (broken && t == bad_at) put_bad_token();
            else if ($urandom_range(0, 9) == 0) put_comment();
            else put_good_token();
            if (t != n_tok - 1 || $urandom_range(0, 1)) begin
                put_sep();
                if ($urandom_range(0, 5) == 0) put_sep();
            end
        end
        put_end();
    endtask

    // hold the sender until every expected word has come back
    task automatic drain();
        while (text_q.size() != 0 || s_valid || parsed_q.size() != 0) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int unsigned start_cnt;
        int          n_text;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extreme bytes with a prefix
        put_str("0xFF 00");
        put_end();
        // comment, crlf, then a bare prefix on line two
        put_str("#a");
        put_char(CH_CR);
        put_char(CH_LF);
        put_str("0x");
        put_end();
        // lone slash followed by a separator
        put_str("/");
        put_char(CH_TAB);
        put_end();
        // prefix then a single digit
        put_str("0XA");
        put_end();
        // mark inside a token, then everything ignored, line break too
        put_str("1/");
        put_char(CH_LF);
        put_str("F");
        put_end();
        // extreme code units that are not hex
        put_char(16'hFFFF);
        put_end();
        put_char(16'h0000);
        put_end();
        drain();

        // random texts
        start_cnt = words_fed;
        n_text    = 0;
        while (words_fed - start_cnt < RANDOM_WORDS) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            put_text();
            n_text++;
            if (n_text % 6 == 0) drain();
        end
        no_gaps = 1'b0;
        drain();

        // a short clean text to finish
        put_str("0x1234");
        put_end();
        drain();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && parsed_q.size() == 0) begin
            $display("hex_text_to_byte_parser_core_tb: done, clean");
        end else begin
            $display("hex_text_to_byte_parser_core_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hexp_pkg.sv
rtl/hexp_parse.sv
rtl/hex_text_to_byte_parser_core.sv
rtl/hexp_checker.sv
tb/hex_text_to_byte_parser_core_tb.sv
